// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while reset is active.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in the same cycle.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed one cycle later.");

`endif

// ===== sv/cycts_pkg.sv =====
// ----------------------------------------------------------------------------
// Cycle count time split package
// Types and fixed constants shared by the time split block and its checker.
// ----------------------------------------------------------------------------
package cycts_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WRAP_W   = 32;
    localparam int TOTAL_W  = 64;
    localparam int CLOCK_W  = 10;
    localparam int SEC_W    = 45;
    localparam int SUB_W    = 10;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = 10'd168;
    localparam logic [SUB_W-1:0]   SUB_PER_UNIT = 10'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

endpackage

// ===== sv/cycle_count_to_time_split.sv =====
// Each accepted item runs through a bit-serial division loop that shifts one
// bit of the 64-bit extended count per cycle; no new item is accepted until
// its result has been loaded into the output register.
// A finished result waits in the output register while the next item runs.
// Reset clears the previous sample, the wrap count and the state machine,
// and sets the clock register to 168 MHz.
// ----------------------------------------------------------------------------
// Cycle count to time split
// Extends a cycle counter sample with a wrap count and splits the total into
// seconds, milliseconds, microseconds and total microseconds by three chained
// radix-2 dividers that share one bit stream.
// ----------------------------------------------------------------------------
module cycle_count_to_time_split #(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cycts_pkg::CLOCK_W-1:0]       clock_mhz,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cycts_pkg::SAMPLE_W-1:0]      counter_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cycts_pkg::SEC_W-1:0]         seconds,
    output logic [cycts_pkg::SUB_W-1:0]         milliseconds,
    output logic [cycts_pkg::SUB_W-1:0]         microseconds,
    output logic [cycts_pkg::TOTAL_W-1:0]       total_microseconds,
    output logic                                wrapped
);
    import cycts_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((64'd1 << COUNTER_WIDTH) - 64'd1);
    localparam int CNT_W = $clog2(TOTAL_W);
    localparam int REM_W = CLOCK_W + 1;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CLOCK_W-1:0]     clock_reg, clock_next;
    logic [SAMPLE_W-1:0]    last_reg, last_next;
    logic [WRAP_W-1:0]      wrap_reg, wrap_next;
    logic                   out_valid_reg, out_valid_next;

    logic [TOTAL_W-1:0]     tot_reg, tot_next;
    logic [TOTAL_W-1:0]     tus_reg, tus_next;
    logic [SEC_W-1:0]       sec_reg, sec_next;
    logic [CLOCK_W-1:0]     ra_reg, ra_next;
    logic [SUB_W-1:0]       rb_reg, rb_next;
    logic [SUB_W-1:0]       rc_reg, rc_next;
    logic                   wflag_reg, wflag_next;

    logic [SEC_W-1:0]       o_sec_reg;
    logic [SUB_W-1:0]       o_ms_reg;
    logic [SUB_W-1:0]       o_us_reg;
    logic [TOTAL_W-1:0]     o_tus_reg;
    logic                   o_wrap_reg;

    logic                   accept;
    logic                   run;
    logic                   load;
    logic                   last_bit;
    logic [SAMPLE_W-1:0]    sample;
    logic                   is_wrap;
    logic [CLOCK_W-1:0]     mhz;
    logic [REM_W-1:0]       ta, tb, tc;
    logic                   qa, qb, qc;
    logic [REM_W-1:0]       na, nb, nc;

    assign accept   = in_valid && !in_stall;
    assign last_bit = (cnt_reg == CNT_W'(TOTAL_W - 1));
    assign sample   = counter_value & SAMPLE_MASK;
    assign is_wrap  = (sample < last_reg);
    assign mhz      = (clock_reg == '0) ? CLOCK_W'(1) : clock_reg;

    // One bit of the total enters the divider by the clock; each quotient bit
    // feeds the first divider by 1000, whose quotient bit feeds the second.
    always_comb
    begin
        ta = {ra_reg, tot_reg[TOTAL_W-1]};
        qa = (ta >= {1'b0, mhz});
        na = qa ? (ta - {1'b0, mhz}) : ta;
        tb = {rb_reg, qa};
        qb = (tb >= {1'b0, SUB_PER_UNIT});
        nb = qb ? (tb - {1'b0, SUB_PER_UNIT}) : tb;
        tc = {rc_reg, qb};
        qc = (tc >= {1'b0, SUB_PER_UNIT});
        nc = qc ? (tc - {1'b0, SUB_PER_UNIT}) : tc;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_bit)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        run      = 1'b0;
        load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RUN:
            begin
                run = 1'b1;
            end
            ST_DONE:
            begin
                load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        clock_next     = clock_reg;
        last_next      = last_reg;
        wrap_next      = wrap_reg;
        out_valid_next = out_valid_reg;
        tot_next       = tot_reg;
        tus_next       = tus_reg;
        sec_next       = sec_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        rc_next        = rc_reg;
        wflag_next     = wflag_reg;

        if (cfg_valid && cfg_ready)
        begin
            clock_next = clock_mhz;
        end

        if (accept)
        begin
            wrap_next  = is_wrap ? (wrap_reg + WRAP_W'(1)) : wrap_reg;
            last_next  = sample;
            wflag_next = is_wrap;
            tot_next   = (TOTAL_W'(wrap_next) << COUNTER_WIDTH) | TOTAL_W'(sample);
            cnt_next   = '0;
            ra_next    = '0;
            rb_next    = '0;
            rc_next    = '0;
        end
        else if (run)
        begin
            tot_next = {tot_reg[TOTAL_W-2:0], 1'b0};
            tus_next = {tus_reg[TOTAL_W-2:0], qa};
            sec_next = {sec_reg[SEC_W-2:0], qc};
            ra_next  = na[CLOCK_W-1:0];
            rb_next  = nb[SUB_W-1:0];
            rc_next  = nc[SUB_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            clock_reg     <= CLOCK_RESET;
            last_reg      <= '0;
            wrap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clock_reg     <= clock_next;
            last_reg      <= last_next;
            wrap_reg      <= wrap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg   <= tot_next;
        tus_reg   <= tus_next;
        sec_reg   <= sec_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rc_reg    <= rc_next;
        wflag_reg <= wflag_next;
        if (load)
        begin
            o_sec_reg  <= sec_reg;
            o_ms_reg   <= rc_reg;
            o_us_reg   <= rb_reg;
            o_tus_reg  <= tus_reg;
            o_wrap_reg <= wflag_reg;
        end
    end

    assign cfg_ready          = 1'b1;
    assign out_valid          = out_valid_reg;
    assign seconds            = o_sec_reg;
    assign milliseconds       = o_ms_reg;
    assign microseconds       = o_us_reg;
    assign total_microseconds = o_tus_reg;
    assign wrapped            = o_wrap_reg;

endmodule

// ===== sv/cycts_check.sv =====
// ----------------------------------------------------------------------------
// Cycle count time split checker
// Port-level assertions on the time split block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cycts_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [cycts_pkg::SUB_W-1:0]         milliseconds,
    input  logic [cycts_pkg::SUB_W-1:0]         microseconds,
    input  logic [cycts_pkg::TOTAL_W-1:0]       total_microseconds
);
    import cycts_pkg::*;

    `ASSERT_SAME(a_ms_range, clk, rst_n, out_valid, milliseconds < SUB_PER_UNIT)
    `ASSERT_SAME(a_us_range, clk, rst_n, out_valid, microseconds < SUB_PER_UNIT)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(total_microseconds))

endmodule

bind cycle_count_to_time_split cycts_check u_cycts_check (.*);
